@@ src/assert_macros.svh @@
// Assertion macros for the metric line tagger
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define STL_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Antecedent implies consequent on the same edge.
`define STL_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

@@ src/stl_pkg.sv @@
// Shared types, codes and the byte classifier for the metric line tagger
package stl_pkg;

	localparam int TOK_DEPTH_DEF = 2;
	localparam int RES_DEPTH_DEF = 2;

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_ZERO   = 8'h00;

	localparam logic [2:0] CLS_OTHER  = 3'd0;
	localparam logic [2:0] CLS_LBRACK = 3'd1;
	localparam logic [2:0] CLS_RBRACK = 3'd2;
	localparam logic [2:0] CLS_COLON  = 3'd3;
	localparam logic [2:0] CLS_EQ     = 3'd4;
	localparam logic [2:0] CLS_ZERO   = 3'd5;

	localparam logic [2:0] PH_KEY    = 3'd0;
	localparam logic [2:0] PH_AFTER  = 3'd1;
	localparam logic [2:0] PH_LABEL  = 3'd2;
	localparam logic [2:0] PH_VALUE  = 3'd3;
	localparam logic [2:0] PH_IGNORE = 3'd4;

	localparam logic [2:0] ROLE_KEY   = 3'd0;
	localparam logic [2:0] ROLE_NAME  = 3'd1;
	localparam logic [2:0] ROLE_LVAL  = 3'd2;
	localparam logic [2:0] ROLE_SVAL  = 3'd3;
	localparam logic [2:0] ROLE_DELIM = 3'd4;
	localparam logic [2:0] ROLE_NONE  = 3'd5;

	localparam logic [1:0] DONE_NONE   = 2'd0;
	localparam logic [1:0] DONE_KEY    = 2'd1;
	localparam logic [1:0] DONE_LABEL  = 2'd2;
	localparam logic [1:0] DONE_SAMPLE = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_EQ_IN_KEY = 2'd1;
	localparam logic [1:0] ERR_BAD_LABEL = 2'd2;
	localparam logic [1:0] ERR_AFTER_LBL = 2'd3;

	typedef struct packed {
		logic       eol;
		logic [2:0] cls;
	} tok_t;

	typedef struct packed {
		logic [2:0] role;
		logic [1:0] done;
		logic [1:0] err;
		logic       ld;
	} res_t;

	function automatic logic [2:0] classify(input logic [7:0] b);
		logic [2:0] c;
		unique case (b)
			CH_LBRACK: c = CLS_LBRACK;
			CH_RBRACK: c = CLS_RBRACK;
			CH_COLON:  c = CLS_COLON;
			CH_EQ:     c = CLS_EQ;
			CH_ZERO:   c = CLS_ZERO;
			default:   c = CLS_OTHER;
		endcase
		return c;
	endfunction

endpackage

@@ src/stl_queue.sv @@
// Small first-in first-out queue with registered storage
module stl_queue #(
	parameter int DEPTH = stl_pkg::TOK_DEPTH_DEF,
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

@@ src/stl_front.sv @@
// Front end: takes input beats and classifies each byte into a token
module stl_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [7:0]   in_byte,
	input  logic         line_end,
	output logic         full,
	output logic         tok_valid,
	output stl_pkg::tok_t tok,
	input  logic         tok_full
);

	logic          v_s1;
	stl_pkg::tok_t tok_s1;
	logic          advance;

	assign advance   = !v_s1 || !tok_full;
	assign full      = !advance;
	assign tok_valid = v_s1;
	assign tok       = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			tok_s1.eol <= line_end;
			tok_s1.cls <= stl_pkg::classify(in_byte);
		end
	end

endmodule

@@ src/stl_back.sv @@
// Back end: parse state machine that turns tokens into tagged results
module stl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tok_empty,
	input  stl_pkg::tok_t tok,
	output logic          tok_pop,
	input  logic          res_full,
	output logic          res_push,
	output stl_pkg::res_t res
);

	logic [2:0] phase_q;
	logic       equal_q;
	logic       nonempty_q;
	logic [2:0] phase_d;
	logic       equal_d;
	logic       nonempty_d;
	logic       take;
	logic       label_ok;
	logic       lbl_end;

	assign take     = !tok_empty && !res_full;
	assign tok_pop  = take;
	assign res_push = take;
	assign label_ok = equal_q && nonempty_q;
	assign lbl_end  = (tok.cls == stl_pkg::CLS_RBRACK) || (tok.cls == stl_pkg::CLS_COLON)
		|| (tok.cls == stl_pkg::CLS_ZERO);

	always_comb begin
		res.role   = stl_pkg::ROLE_NONE;
		res.done   = stl_pkg::DONE_NONE;
		res.err    = stl_pkg::ERR_NONE;
		res.ld     = 1'b0;
		phase_d    = phase_q;
		equal_d    = equal_q;
		nonempty_d = nonempty_q;
		if (tok.eol) begin
			res.ld     = 1'b1;
			phase_d    = stl_pkg::PH_KEY;
			equal_d    = 1'b0;
			nonempty_d = 1'b0;
			unique case (phase_q)
				stl_pkg::PH_KEY:   res.done = stl_pkg::DONE_KEY;
				stl_pkg::PH_LABEL: begin
					if (label_ok) begin
						res.done = stl_pkg::DONE_LABEL;
					end else begin
						res.err = stl_pkg::ERR_BAD_LABEL;
					end
				end
				stl_pkg::PH_AFTER: res.err  = stl_pkg::ERR_AFTER_LBL;
				stl_pkg::PH_VALUE: res.done = stl_pkg::DONE_SAMPLE;
				default: ;
			endcase
		end else begin
			unique case (phase_q)
				stl_pkg::PH_KEY: begin
					priority if (tok.cls == stl_pkg::CLS_LBRACK) begin
						res.role   = stl_pkg::ROLE_DELIM;
						res.done   = stl_pkg::DONE_KEY;
						phase_d    = stl_pkg::PH_LABEL;
						equal_d    = 1'b0;
						nonempty_d = 1'b0;
					end else if (tok.cls == stl_pkg::CLS_COLON || tok.cls == stl_pkg::CLS_ZERO) begin
						res.role = stl_pkg::ROLE_DELIM;
						res.done = stl_pkg::DONE_KEY;
						phase_d  = stl_pkg::PH_VALUE;
					end else if (tok.cls == stl_pkg::CLS_EQ) begin
						res.err = stl_pkg::ERR_EQ_IN_KEY;
						phase_d = stl_pkg::PH_IGNORE;
					end else begin
						res.role = stl_pkg::ROLE_KEY;
					end
				end
				stl_pkg::PH_AFTER: begin
					priority if (tok.cls == stl_pkg::CLS_LBRACK) begin
						res.role   = stl_pkg::ROLE_DELIM;
						phase_d    = stl_pkg::PH_LABEL;
						equal_d    = 1'b0;
						nonempty_d = 1'b0;
					end else if (tok.cls == stl_pkg::CLS_COLON) begin
						res.role = stl_pkg::ROLE_DELIM;
						phase_d  = stl_pkg::PH_VALUE;
					end else begin
						res.err = stl_pkg::ERR_AFTER_LBL;
						phase_d = stl_pkg::PH_IGNORE;
					end
				end
				stl_pkg::PH_LABEL: begin
					priority if (lbl_end) begin
						if (label_ok) begin
							res.role = stl_pkg::ROLE_DELIM;
							res.done = stl_pkg::DONE_LABEL;
							phase_d  = stl_pkg::PH_AFTER;
						end else begin
							res.err = stl_pkg::ERR_BAD_LABEL;
							phase_d = stl_pkg::PH_IGNORE;
						end
					end else if (equal_q) begin
						res.role   = stl_pkg::ROLE_LVAL;
						nonempty_d = 1'b1;
					end else if (tok.cls == stl_pkg::CLS_EQ) begin
						res.role = stl_pkg::ROLE_DELIM;
						equal_d  = 1'b1;
					end else begin
						res.role = stl_pkg::ROLE_NAME;
					end
				end
				stl_pkg::PH_VALUE: res.role = stl_pkg::ROLE_SVAL;
				default:           phase_d  = stl_pkg::PH_IGNORE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= stl_pkg::PH_KEY;
			equal_q    <= 1'b0;
			nonempty_q <= 1'b0;
		end else if (take) begin
			phase_q    <= phase_d;
			equal_q    <= equal_d;
			nonempty_q <= nonempty_d;
		end
	end

endmodule

@@ src/statsd_line_tokenizer_core.sv @@
// Top level of the metric line byte tagger
// Tags each byte of a line key[name=val]...:value with its role.
// Input channel: a beat (in_byte, line_end) is taken when push is high and
// full is low; line_end marks the end of a line and carries no byte.
// Result channel: while empty is low the oldest result (byte_role,
// field_done, parse_error, line_done) is on the ports; it is taken when pop
// is high. Exactly one result per input beat, in order.
// A taken beat passes the classifier register, the token queue and the result
// queue before it can be popped. Throughput is one beat per cycle while pop
// keeps the result queue from filling; the back end updates its parse state
// once per token.
// When pop stays low the result queue fills, the back end stops, the token
// queue fills and full rises; nothing is dropped.
// arst_n clears all queues and returns the parser to the key phase; no
// results are pending after reset.
`include "assert_macros.svh"

module statsd_line_tokenizer_core #(
	parameter int TOK_DEPTH = stl_pkg::TOK_DEPTH_DEF,
	parameter int RES_DEPTH = stl_pkg::RES_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       line_end,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] byte_role,
	output logic [1:0] field_done,
	output logic [1:0] parse_error,
	output logic       line_done
);

	localparam int TW = $bits(stl_pkg::tok_t);
	localparam int RW = $bits(stl_pkg::res_t);

	logic          fe_valid;
	stl_pkg::tok_t fe_tok;
	logic          tq_full;
	logic          tq_empty;
	logic          tq_pop;
	stl_pkg::tok_t tq_tok;
	logic          rq_full;
	logic          rq_push;
	stl_pkg::res_t be_res;
	stl_pkg::res_t rq_res;

	stl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_byte   (in_byte),
		.line_end  (line_end),
		.full      (full),
		.tok_valid (fe_valid),
		.tok       (fe_tok),
		.tok_full  (tq_full)
	);

	stl_queue #(
		.DEPTH (TOK_DEPTH),
		.WIDTH (TW)
	) u_tok_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_valid),
		.wr_data (fe_tok),
		.full    (tq_full),
		.rd_en   (tq_pop),
		.rd_data (tq_tok),
		.empty   (tq_empty)
	);

	stl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (tq_empty),
		.tok       (tq_tok),
		.tok_pop   (tq_pop),
		.res_full  (rq_full),
		.res_push  (rq_push),
		.res       (be_res)
	);

	stl_queue #(
		.DEPTH (RES_DEPTH),
		.WIDTH (RW)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_push),
		.wr_data (be_res),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (rq_res),
		.empty   (empty)
	);

	assign byte_role   = rq_res.role;
	assign field_done  = rq_res.done;
	assign parse_error = rq_res.err;
	assign line_done   = rq_res.ld;

	`STL_ASSERT_IMPL(a_eol_no_role, !empty && line_done, byte_role == stl_pkg::ROLE_NONE)
	`STL_ASSERT_IMPL(a_err_no_role, !empty && parse_error != stl_pkg::ERR_NONE,
		byte_role == stl_pkg::ROLE_NONE)
	`STL_ASSERT_IMPL(a_done_xor_err, !empty,
		field_done == stl_pkg::DONE_NONE || parse_error == stl_pkg::ERR_NONE)
	`STL_ASSERT_ALWAYS(a_back_no_overrun, !(rq_push && rq_full))

endmodule
